// ===== rtl/htlp_pkg.sv =====
`timescale 1ns / 1ps

package htlp_pkg;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_READY = 2'd1,
		KIND_ERROR = 2'd2,
		KIND_END   = 2'd3
	} htlp_kind_t;

	// Parser phase
	typedef enum logic [1:0] {
		PH_FIRST   = 2'd0,
		PH_SECOND  = 2'd1,
		PH_COMMENT = 2'd2,
		PH_DISCARD = 2'd3
	} htlp_phase_t;

	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_HASH = 8'h23;
	localparam logic [7:0] CHAR_EOF  = 8'h00;

	localparam logic [5:0] LINE_LENGTH_RESET = 6'd20;

	// Register indexes
	localparam logic REG_LINE_LENGTH = 1'b0;

	// Case-insensitive hex digit; anything else decodes to zero
	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [3:0] n;
		n = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			n = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			n = c[3:0] + 4'd9;
		end
		return n;
	endfunction

endpackage

// ===== rtl/htlp_stream_if.sv =====
`timescale 1ns / 1ps

// Character channel
interface htlp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;

	modport source(output valid, output text_char, input ready);
	modport sink(input valid, input text_char, output ready);
endinterface

// Result channel
interface htlp_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [5:0] byte_index;

	modport source(output valid, output kind, output data_byte, output byte_index,
		input ready);
	modport sink(input valid, input kind, input data_byte, input byte_index,
		output ready);
endinterface

// ===== rtl/htlp_core.sv =====
`timescale 1ns / 1ps

module htlp_core import htlp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [5:0]   line_length,
	htlp_char_if.sink    char_in,
	htlp_res_if.source   res_out
);

	// Input register
	logic        valid_s1;
	logic [7:0]  char_s1;

	// Result register
	logic        valid_s2;
	htlp_kind_t  kind_s2;
	logic [7:0]  data_s2;
	logic [5:0]  index_s2;

	// Parser state
	htlp_phase_t phase_q;
	logic [3:0]  high_nibble_q;
	logic [5:0]  byte_count_q;

	logic        s2_free;
	logic        advance;
	logic        in_ready;

	htlp_phase_t phase_d;
	logic [3:0]  high_nibble_d;
	logic [5:0]  byte_count_d;
	logic        emit;
	htlp_kind_t  kind_d;
	logic [7:0]  data_d;
	logic [5:0]  index_d;

	assign s2_free  = !valid_s2 || res_out.ready;
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	assign char_in.ready      = in_ready;
	assign res_out.valid      = valid_s2;
	assign res_out.kind       = kind_s2;
	assign res_out.data_byte  = data_s2;
	assign res_out.byte_index = index_s2;

	// Step logic for one character
	always_comb begin
		phase_d       = phase_q;
		high_nibble_d = high_nibble_q;
		byte_count_d  = byte_count_q;
		emit          = 1'b0;
		kind_d        = KIND_DATA;
		data_d        = 8'd0;
		index_d       = byte_count_q;
		case (phase_q)
			PH_FIRST: begin
				if (char_s1 == CHAR_HASH) begin
					phase_d = PH_COMMENT;
				end else if (char_s1 == CHAR_CR) begin
					phase_d = PH_DISCARD;
					if (byte_count_q != 6'd0) begin
						emit         = 1'b1;
						kind_d       = (byte_count_q == line_length) ? KIND_READY : KIND_ERROR;
						byte_count_d = 6'd0;
					end
				end else if (char_s1 == CHAR_EOF) begin
					emit         = 1'b1;
					kind_d       = KIND_END;
					byte_count_d = 6'd0;
				end else begin
					high_nibble_d = hex_nibble(char_s1);
					phase_d       = PH_SECOND;
				end
			end
			PH_SECOND: begin
				phase_d = PH_FIRST;
				emit    = 1'b1;
				if (byte_count_q >= line_length) begin
					kind_d       = KIND_ERROR;
					byte_count_d = 6'd0;
				end else begin
					kind_d       = KIND_DATA;
					data_d       = {high_nibble_q, hex_nibble(char_s1)};
					byte_count_d = byte_count_q + 6'd1;
				end
			end
			PH_COMMENT: begin
				if (char_s1 == CHAR_EOF) begin
					phase_d      = PH_FIRST;
					emit         = 1'b1;
					kind_d       = KIND_END;
					byte_count_d = 6'd0;
				end else if (char_s1 == CHAR_CR) begin
					phase_d = PH_DISCARD;
					if (byte_count_q != 6'd0) begin
						emit         = 1'b1;
						kind_d       = (byte_count_q == line_length) ? KIND_READY : KIND_ERROR;
						byte_count_d = 6'd0;
					end
				end
			end
			PH_DISCARD: begin
				phase_d = PH_FIRST;
			end
			default: begin
				phase_d = PH_FIRST;
			end
		endcase
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= char_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && char_in.valid) begin
			char_s1 <= char_in.text_char;
		end
	end

	// Parser state, updated once per character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_FIRST;
			high_nibble_q <= 4'd0;
			byte_count_q  <= 6'd0;
		end else if (advance) begin
			phase_q       <= phase_d;
			high_nibble_q <= high_nibble_d;
			byte_count_q  <= byte_count_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_s2  <= kind_d;
			data_s2  <= data_d;
			index_s2 <= index_d;
		end
	end

	// Only data transactions carry a byte
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && kind_s2 != KIND_DATA) |-> (data_s2 == 8'd0))
		else $error("non-data result carries a byte");

	// A data byte always lies inside the configured line
	a_data_index: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && kind_s2 == KIND_DATA) |-> (index_s2 < line_length))
		else $error("data byte beyond line length");

	// Ready report means the count matched
	a_ready_count: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && kind_s2 == KIND_READY) |-> (index_s2 == line_length))
		else $error("line ready with wrong count");

	// The character after CR is dropped and parsing resumes at a pair start
	a_discard: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == PH_DISCARD) |=> (phase_q == PH_FIRST && !valid_s2))
		else $error("discarded character left state or result");

endmodule

// ===== rtl/hex_text_line_parser.sv =====
`timescale 1ns / 1ps

// Hex text line parser. Takes one text character per transaction and turns pairs
// of hex digits into data bytes tagged with their position in the line; at CR it
// reports line ready or format error against the programmed line_length (reset 20),
// and a zero character reports end of file. It takes one character per clock while
// results are taken; a result passes from the input register through the single
// parser state update step into the result register. A held result lets one more
// character into the input register; once that register is also full, the input
// stalls until the result is taken. line_length sits at byte address 0 of the APB
// port; the user must write it only while idle, and the block does not enforce it.

module hex_text_line_parser import htlp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	htlp_char_if.sink    char_in,
	htlp_res_if.source   res_out
);

	logic [5:0] line_length_q;
	logic       reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_LINE_LENGTH);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LINE_LENGTH_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			line_length_q <= pwdata[5:0];
		end
	end

	// Read back
	always_comb begin
		prdata = 32'd0;
		if (reg_sel) begin
			prdata = {26'd0, line_length_q};
		end
	end

	htlp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.line_length (line_length_q),
		.char_in     (char_in),
		.res_out     (res_out)
	);

endmodule
